FILE: src/rsqe_pkg.sv
// Shared types, constants and helpers of the road segment quad expander.
package rsqe_pkg;

  localparam int CoordW  = 32;
  localparam int WidthW  = 16;
  localparam int CfgW    = 16;
  localparam int IdxW    = 8;
  localparam int MagW    = 32;
  localparam int HalfMagW = 31;
  localparam int SqW     = 62;
  localparam int RadW    = 64;
  localparam int LenW    = 33;
  localparam int HwW     = 23;
  localparam int ProdW   = 55;
  localparam int NumW    = 56;
  localparam int WideW   = 64;
  localparam int DivCntW = 6;

  localparam logic [CfgW-1:0] RoadHeightReset = 16'd3277;
  localparam logic [CfgW-1:0] MinLengthReset  = 16'd1;

  localparam logic [IdxW-1:0] RegRoadHeight = 8'd0;
  localparam logic [IdxW-1:0] RegMinLength  = 8'd1;

  localparam logic [DivCntW-1:0] DivLast = 6'(NumW - 1);

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQ_A,
    CMD_SQ_B,
    CMD_SUM,
    CMD_SQRT,
    CMD_LEN,
    CMD_MUL_Z,
    CMD_MUL_X,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_SAVE_Z,
    CMD_SAVE_X,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic sqrt_last;
    logic div_last;
    logic short_seg;
    logic out_busy;
  } stat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic [CoordW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

endpackage

FILE: src/rsqe_if.sv
// Stream and configuration channel interfaces of the quad expander.
interface rsqe_pt_if;
  logic                              valid;
  logic                              ready;
  logic signed [rsqe_pkg::CoordW-1:0] point_x;
  logic signed [rsqe_pkg::CoordW-1:0] point_z;
  logic [rsqe_pkg::WidthW-1:0]        road_width;
  logic                              polyline_start;
  modport source (output valid, point_x, point_z, road_width, polyline_start, input ready);
  modport sink (input valid, point_x, point_z, road_width, polyline_start, output ready);
endinterface

interface rsqe_quad_if;
  logic                              valid;
  logic                              ready;
  logic [rsqe_pkg::CoordW-1:0]        base_index;
  logic signed [rsqe_pkg::CoordW-1:0] corner_a_x;
  logic signed [rsqe_pkg::CoordW-1:0] corner_a_z;
  logic signed [rsqe_pkg::CoordW-1:0] corner_b_x;
  logic signed [rsqe_pkg::CoordW-1:0] corner_b_z;
  logic signed [rsqe_pkg::CoordW-1:0] corner_c_x;
  logic signed [rsqe_pkg::CoordW-1:0] corner_c_z;
  logic signed [rsqe_pkg::CoordW-1:0] corner_d_x;
  logic signed [rsqe_pkg::CoordW-1:0] corner_d_z;
  logic [rsqe_pkg::CfgW-1:0]          vertex_height;
  modport source (output valid, base_index, corner_a_x, corner_a_z, corner_b_x, corner_b_z,
                  corner_c_x, corner_c_z, corner_d_x, corner_d_z, vertex_height,
                  input ready);
  modport sink (input valid, base_index, corner_a_x, corner_a_z, corner_b_x, corner_b_z,
                corner_c_x, corner_c_z, corner_d_x, corner_d_z, vertex_height,
                output ready);
endinterface

interface rsqe_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rsqe_pkg::IdxW-1:0]  index;
  logic [rsqe_pkg::CfgW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/rsqe_ctrl.sv
// Sequencing state machine of the quad expander.
module rsqe_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            pt_valid,
  input  logic            pt_start,
  output logic            pt_ready,
  input  rsqe_pkg::stat_t stat,
  output rsqe_pkg::cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_SQA  = 16'h0002,
    S_SQB  = 16'h0004,
    S_SUM  = 16'h0008,
    S_SQRT = 16'h0010,
    S_LEN  = 16'h0020,
    S_CHK  = 16'h0040,
    S_MULZ = 16'h0080,
    S_DINZ = 16'h0100,
    S_DIVZ = 16'h0200,
    S_SVZ  = 16'h0400,
    S_MULX = 16'h0800,
    S_DINX = 16'h1000,
    S_DIVX = 16'h2000,
    S_SVX  = 16'h4000,
    S_EMIT = 16'h8000
  } state_t;

  state_t state, state_next;

  assign pt_ready = (state == S_IDLE);

  // Pick the next state and the datapath command.
  always_comb begin
    state_next = state;
    cmd        = rsqe_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (pt_valid) begin
          cmd = rsqe_pkg::CMD_LOAD;
          if (!pt_start && stat.have_prev) state_next = S_SQA;
        end
      end
      S_SQA: begin
        cmd = rsqe_pkg::CMD_SQ_A;
        state_next = S_SQB;
      end
      S_SQB: begin
        cmd = rsqe_pkg::CMD_SQ_B;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd = rsqe_pkg::CMD_SUM;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd = rsqe_pkg::CMD_SQRT;
        if (stat.sqrt_last) state_next = S_LEN;
      end
      S_LEN: begin
        cmd = rsqe_pkg::CMD_LEN;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = stat.short_seg ? S_IDLE : S_MULZ;
      end
      S_MULZ: begin
        cmd = rsqe_pkg::CMD_MUL_Z;
        state_next = S_DINZ;
      end
      S_DINZ: begin
        cmd = rsqe_pkg::CMD_DIV_INIT;
        state_next = S_DIVZ;
      end
      S_DIVZ: begin
        cmd = rsqe_pkg::CMD_DIV_STEP;
        if (stat.div_last) state_next = S_SVZ;
      end
      S_SVZ: begin
        cmd = rsqe_pkg::CMD_SAVE_Z;
        state_next = S_MULX;
      end
      S_MULX: begin
        cmd = rsqe_pkg::CMD_MUL_X;
        state_next = S_DINX;
      end
      S_DINX: begin
        cmd = rsqe_pkg::CMD_DIV_INIT;
        state_next = S_DIVX;
      end
      S_DIVX: begin
        cmd = rsqe_pkg::CMD_DIV_STEP;
        if (stat.div_last) state_next = S_SVX;
      end
      S_SVX: begin
        cmd = rsqe_pkg::CMD_SAVE_X;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd = rsqe_pkg::CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result is only produced while the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd == rsqe_pkg::CMD_EMIT |-> !stat.out_busy) else $error("emit into busy output");
  // Accepting a word only happens from idle.
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd == rsqe_pkg::CMD_LOAD |-> pt_ready) else $error("load outside idle");
  // A finished emit returns to idle.
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd == rsqe_pkg::CMD_EMIT |=> state == S_IDLE) else $error("emit did not return to idle");

endmodule

FILE: src/rsqe_dp.sv
// Datapath: point state, squares, iterative root, shared divider, corners.
module rsqe_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  rsqe_pkg::cmd_t                    cmd,
  output rsqe_pkg::stat_t                   stat,
  input  logic signed [rsqe_pkg::CoordW-1:0] point_x,
  input  logic signed [rsqe_pkg::CoordW-1:0] point_z,
  input  logic [rsqe_pkg::WidthW-1:0]        road_width,
  input  logic                              polyline_start,
  input  logic                              cfg_we,
  input  logic [rsqe_pkg::IdxW-1:0]          cfg_index,
  input  logic [rsqe_pkg::CfgW-1:0]          cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [rsqe_pkg::CoordW-1:0]        base_index,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_a_x,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_a_z,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_b_x,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_b_z,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_c_x,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_c_z,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_d_x,
  output logic signed [rsqe_pkg::CoordW-1:0] corner_d_z,
  output logic [rsqe_pkg::CfgW-1:0]          vertex_height
);

  logic [rsqe_pkg::CfgW-1:0]          road_height;
  logic [rsqe_pkg::CfgW-1:0]          min_length;
  logic signed [rsqe_pkg::CoordW-1:0] prev_x, prev_z, seg_x, seg_z;
  logic [rsqe_pkg::WidthW-1:0]        half_width;
  logic                              have_prev;
  logic [rsqe_pkg::CoordW-1:0]        vertex_count;
  logic                              neg_x, neg_z, sh;
  logic [rsqe_pkg::MagW-1:0]          mag_x, mag_z;
  logic [rsqe_pkg::HalfMagW-1:0]      sq_ax, sq_az;
  logic [rsqe_pkg::SqW-1:0]           prod, acc;
  logic [rsqe_pkg::RadW-1:0]          sq_v, sq_r, sq_bit;
  logic [rsqe_pkg::LenW-1:0]          len;
  logic [rsqe_pkg::ProdW-1:0]         prod_n;
  logic [rsqe_pkg::NumW-1:0]          div_n, q_z, q_x;
  logic [rsqe_pkg::LenW-1:0]          div_r;
  logic [rsqe_pkg::DivCntW-1:0]       div_cnt;

  logic signed [rsqe_pkg::LenW-1:0]   dx, dz;
  logic [rsqe_pkg::LenW-1:0]          adx, adz;
  logic [rsqe_pkg::RadW-1:0]          sq_t;
  logic [rsqe_pkg::LenW:0]            div_t;
  logic [rsqe_pkg::HwW-1:0]           hw;
  logic signed [rsqe_pkg::WideW-1:0]  ox, oz, px, pz, cx, cz;

  // Deltas to the stored point and their magnitudes.
  always_comb begin
    dx  = rsqe_pkg::LenW'(point_x) - rsqe_pkg::LenW'(prev_x);
    dz  = rsqe_pkg::LenW'(point_z) - rsqe_pkg::LenW'(prev_z);
    adx = dx[rsqe_pkg::LenW-1] ? -dx : dx;
    adz = dz[rsqe_pkg::LenW-1] ? -dz : dz;
  end

  assign hw = {half_width, 7'b0};
  assign sq_t = sq_r + sq_bit;
  assign div_t = {div_r, div_n[rsqe_pkg::NumW-1]};

  // Signed offsets and the wide corner sums.
  always_comb begin
    ox = neg_z ? rsqe_pkg::WideW'(q_z) : -rsqe_pkg::WideW'(q_z);
    oz = neg_x ? -rsqe_pkg::WideW'(q_x) : rsqe_pkg::WideW'(q_x);
    px = rsqe_pkg::WideW'(seg_x);
    pz = rsqe_pkg::WideW'(seg_z);
    cx = rsqe_pkg::WideW'(prev_x);
    cz = rsqe_pkg::WideW'(prev_z);
  end

  always_comb begin
    stat.have_prev = have_prev;
    stat.sqrt_last = sq_bit[0];
    stat.div_last  = (div_cnt == rsqe_pkg::DivLast);
    stat.short_seg = (len == '0) || (len < rsqe_pkg::LenW'(min_length));
    stat.out_busy  = out_valid;
  end

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      road_height <= rsqe_pkg::RoadHeightReset;
      min_length  <= rsqe_pkg::MinLengthReset;
    end else if (cfg_we) begin
      if (cfg_index == rsqe_pkg::RegRoadHeight) road_height <= cfg_data;
      else if (cfg_index == rsqe_pkg::RegMinLength) min_length <= cfg_data;
    end
  end

  // Point state, output valid and vertex counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x       <= '0;
      prev_z       <= '0;
      half_width   <= '0;
      have_prev    <= 1'b0;
      vertex_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd == rsqe_pkg::CMD_LOAD) begin
        prev_x    <= point_x;
        prev_z    <= point_z;
        have_prev <= 1'b1;
        if (polyline_start) half_width <= road_width;
      end
      if (cmd == rsqe_pkg::CMD_EMIT) begin
        out_valid    <= 1'b1;
        vertex_count <= vertex_count + rsqe_pkg::CoordW'(4);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Arithmetic working registers.
  always_ff @(posedge clk) begin
    case (cmd)
      rsqe_pkg::CMD_LOAD: begin
        seg_x <= prev_x;
        seg_z <= prev_z;
        neg_x <= dx[rsqe_pkg::LenW-1];
        neg_z <= dz[rsqe_pkg::LenW-1];
        mag_x <= adx[rsqe_pkg::MagW-1:0];
        mag_z <= adz[rsqe_pkg::MagW-1:0];
        sh    <= adx[rsqe_pkg::MagW-1] | adz[rsqe_pkg::MagW-1];
        if (adx[rsqe_pkg::MagW-1] | adz[rsqe_pkg::MagW-1]) begin
          sq_ax <= adx[rsqe_pkg::MagW-1:1];
          sq_az <= adz[rsqe_pkg::MagW-1:1];
        end else begin
          sq_ax <= adx[rsqe_pkg::HalfMagW-1:0];
          sq_az <= adz[rsqe_pkg::HalfMagW-1:0];
        end
      end
      rsqe_pkg::CMD_SQ_A: prod <= sq_ax * sq_ax;
      rsqe_pkg::CMD_SQ_B: begin
        acc  <= prod;
        prod <= sq_az * sq_az;
      end
      rsqe_pkg::CMD_SUM: begin
        sq_v   <= rsqe_pkg::RadW'(acc) + rsqe_pkg::RadW'(prod);
        sq_r   <= '0;
        sq_bit <= rsqe_pkg::RadW'(1) << 62;
      end
      rsqe_pkg::CMD_SQRT: begin
        if (sq_v >= sq_t) begin
          sq_v <= sq_v - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      rsqe_pkg::CMD_LEN: begin
        len <= sh ? {sq_r[rsqe_pkg::MagW-1:0], 1'b0} : {1'b0, sq_r[rsqe_pkg::MagW-1:0]};
      end
      rsqe_pkg::CMD_MUL_Z: prod_n <= mag_z * hw;
      rsqe_pkg::CMD_MUL_X: prod_n <= mag_x * hw;
      rsqe_pkg::CMD_DIV_INIT: begin
        div_n   <= rsqe_pkg::NumW'(prod_n) + rsqe_pkg::NumW'(len >> 1);
        div_r   <= '0;
        div_cnt <= '0;
      end
      rsqe_pkg::CMD_DIV_STEP: begin
        if (div_t >= {1'b0, len}) begin
          div_r <= rsqe_pkg::LenW'(div_t - {1'b0, len});
          div_n <= {div_n[rsqe_pkg::NumW-2:0], 1'b1};
        end else begin
          div_r <= div_t[rsqe_pkg::LenW-1:0];
          div_n <= {div_n[rsqe_pkg::NumW-2:0], 1'b0};
        end
        div_cnt <= div_cnt + rsqe_pkg::DivCntW'(1);
      end
      rsqe_pkg::CMD_SAVE_Z: q_z <= div_n;
      rsqe_pkg::CMD_SAVE_X: q_x <= div_n;
      rsqe_pkg::CMD_EMIT: begin
        base_index    <= vertex_count;
        corner_a_x    <= rsqe_pkg::sat32(px - ox);
        corner_a_z    <= rsqe_pkg::sat32(pz - oz);
        corner_b_x    <= rsqe_pkg::sat32(px + ox);
        corner_b_z    <= rsqe_pkg::sat32(pz + oz);
        corner_c_x    <= rsqe_pkg::sat32(cx + ox);
        corner_c_z    <= rsqe_pkg::sat32(cz + oz);
        corner_d_x    <= rsqe_pkg::sat32(cx - ox);
        corner_d_z    <= rsqe_pkg::sat32(cz - oz);
        vertex_height <= road_height;
      end
      default: ;
    endcase
  end

  // The root's scan bit stays a single bit throughout the root.
  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
    cmd == rsqe_pkg::CMD_SQRT |-> $onehot(sq_bit)) else $error("root scan bit lost");
  // The divider remainder stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    cmd == rsqe_pkg::CMD_DIV_STEP |-> div_r < len) else $error("divider remainder too large");
  // Quads are four vertices each, so the base index stays aligned.
  a_base_align: assert property (@(posedge clk) disable iff (rst)
    vertex_count[1:0] == 2'b00) else $error("vertex counter misaligned");

endmodule

FILE: src/road_segment_quad_expander_core.sv
// Top level of the road segment quad expander.
// Start points and first points are taken in idle without leaving it; short segments
// return to idle after the root and length check; a full segment presents its quad and
// returns to idle after both divides, later while the previous quad waits to be taken.
// Throughput: one point at a time (32 root steps, two 56-step divides); cfg taken at once.
// Reset (synchronous, rst high): registers to defaults, no previous point, count 0.
module road_segment_quad_expander_core (
  input  logic    clk,
  input  logic    rst,
  rsqe_pt_if.sink     pt,
  rsqe_quad_if.source quad,
  rsqe_cfg_if.sink    cfg
);

  rsqe_pkg::cmd_t  cmd;
  rsqe_pkg::stat_t stat;
  logic            pt_ready;

  assign pt.ready  = pt_ready;
  assign cfg.ready = 1'b1;

  rsqe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt.valid),
    .pt_start (pt.polyline_start),
    .pt_ready (pt_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsqe_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .point_x        (pt.point_x),
    .point_z        (pt.point_z),
    .road_width     (pt.road_width),
    .polyline_start (pt.polyline_start),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_ready      (quad.ready),
    .out_valid      (quad.valid),
    .base_index     (quad.base_index),
    .corner_a_x     (quad.corner_a_x),
    .corner_a_z     (quad.corner_a_z),
    .corner_b_x     (quad.corner_b_x),
    .corner_b_z     (quad.corner_b_z),
    .corner_c_x     (quad.corner_c_x),
    .corner_c_z     (quad.corner_c_z),
    .corner_d_x     (quad.corner_d_x),
    .corner_d_z     (quad.corner_d_z),
    .vertex_height  (quad.vertex_height)
  );

endmodule
